FILE: design/des_pkg.sv
// ---------------------------------------------------------------------------
// DES package
// Permutation tables, S-boxes and helper functions shared by the DES cells.
// ---------------------------------------------------------------------------
package des_pkg;

  localparam int Rounds = 16;
  localparam int HalfKeyBits = 28;
  localparam int RoundKeyBits = 48;
  localparam int KeyBits = 56;
  localparam int BlockBits = 64;

  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegKey = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMode = 1'b1;

  typedef logic [7:0] tab_entry_t;

  localparam tab_entry_t TabIp [64] = '{
    58, 50, 42, 34, 26, 18, 10, 2, 60, 52, 44, 36, 28, 20, 12, 4,
    62, 54, 46, 38, 30, 22, 14, 6, 64, 56, 48, 40, 32, 24, 16, 8,
    57, 49, 41, 33, 25, 17, 9, 1, 59, 51, 43, 35, 27, 19, 11, 3,
    61, 53, 45, 37, 29, 21, 13, 5, 63, 55, 47, 39, 31, 23, 15, 7};

  localparam tab_entry_t TabFp [64] = '{
    40, 8, 48, 16, 56, 24, 64, 32, 39, 7, 47, 15, 55, 23, 63, 31,
    38, 6, 46, 14, 54, 22, 62, 30, 37, 5, 45, 13, 53, 21, 61, 29,
    36, 4, 44, 12, 52, 20, 60, 28, 35, 3, 43, 11, 51, 19, 59, 27,
    34, 2, 42, 10, 50, 18, 58, 26, 33, 1, 41, 9, 49, 17, 57, 25};

  localparam tab_entry_t TabE [48] = '{
    32, 1, 2, 3, 4, 5, 4, 5, 6, 7, 8, 9,
    8, 9, 10, 11, 12, 13, 12, 13, 14, 15, 16, 17,
    16, 17, 18, 19, 20, 21, 20, 21, 22, 23, 24, 25,
    24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32, 1};

  localparam tab_entry_t TabP [32] = '{
    16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
    2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25};

  localparam tab_entry_t TabPc1 [56] = '{
    57, 49, 41, 33, 25, 17, 9, 1, 58, 50, 42, 34, 26, 18,
    10, 2, 59, 51, 43, 35, 27, 19, 11, 3, 60, 52, 44, 36,
    63, 55, 47, 39, 31, 23, 15, 7, 62, 54, 46, 38, 30, 22,
    14, 6, 61, 53, 45, 37, 29, 21, 13, 5, 28, 20, 12, 4};

  localparam tab_entry_t TabPc2 [48] = '{
    14, 17, 11, 24, 1, 5, 3, 28, 15, 6, 21, 10,
    23, 19, 12, 4, 26, 8, 16, 7, 27, 20, 13, 2,
    41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
    44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32};

  localparam logic [1:0] TabRot [16] = '{
    1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

  localparam logic [3:0] TabSbox [8][64] = '{
    '{14, 4, 13, 1, 2, 15, 11, 8, 3, 10, 6, 12, 5, 9, 0, 7,
      0, 15, 7, 4, 14, 2, 13, 1, 10, 6, 12, 11, 9, 5, 3, 8,
      4, 1, 14, 8, 13, 6, 2, 11, 15, 12, 9, 7, 3, 10, 5, 0,
      15, 12, 8, 2, 4, 9, 1, 7, 5, 11, 3, 14, 10, 0, 6, 13},
    '{15, 1, 8, 14, 6, 11, 3, 4, 9, 7, 2, 13, 12, 0, 5, 10,
      3, 13, 4, 7, 15, 2, 8, 14, 12, 0, 1, 10, 6, 9, 11, 5,
      0, 14, 7, 11, 10, 4, 13, 1, 5, 8, 12, 6, 9, 3, 2, 15,
      13, 8, 10, 1, 3, 15, 4, 2, 11, 6, 7, 12, 0, 5, 14, 9},
    '{10, 0, 9, 14, 6, 3, 15, 5, 1, 13, 12, 7, 11, 4, 2, 8,
      13, 7, 0, 9, 3, 4, 6, 10, 2, 8, 5, 14, 12, 11, 15, 1,
      13, 6, 4, 9, 8, 15, 3, 0, 11, 1, 2, 12, 5, 10, 14, 7,
      1, 10, 13, 0, 6, 9, 8, 7, 4, 15, 14, 3, 11, 5, 2, 12},
    '{7, 13, 14, 3, 0, 6, 9, 10, 1, 2, 8, 5, 11, 12, 4, 15,
      13, 8, 11, 5, 6, 15, 0, 3, 4, 7, 2, 12, 1, 10, 14, 9,
      10, 6, 9, 0, 12, 11, 7, 13, 15, 1, 3, 14, 5, 2, 8, 4,
      3, 15, 0, 6, 10, 1, 13, 8, 9, 4, 5, 11, 12, 7, 2, 14},
    '{2, 12, 4, 1, 7, 10, 11, 6, 8, 5, 3, 15, 13, 0, 14, 9,
      14, 11, 2, 12, 4, 7, 13, 1, 5, 0, 15, 10, 3, 9, 8, 6,
      4, 2, 1, 11, 10, 13, 7, 8, 15, 9, 12, 5, 6, 3, 0, 14,
      11, 8, 12, 7, 1, 14, 2, 13, 6, 15, 0, 9, 10, 4, 5, 3},
    '{12, 1, 10, 15, 9, 2, 6, 8, 0, 13, 3, 4, 14, 7, 5, 11,
      10, 15, 4, 2, 7, 12, 9, 5, 6, 1, 13, 14, 0, 11, 3, 8,
      9, 14, 15, 5, 2, 8, 12, 3, 7, 0, 4, 10, 1, 13, 11, 6,
      4, 3, 2, 12, 9, 5, 15, 10, 11, 14, 1, 7, 6, 0, 8, 13},
    '{4, 11, 2, 14, 15, 0, 8, 13, 3, 12, 9, 7, 5, 10, 6, 1,
      13, 0, 11, 7, 4, 9, 1, 10, 14, 3, 5, 12, 2, 15, 8, 6,
      1, 4, 11, 13, 12, 3, 7, 14, 10, 15, 6, 8, 0, 5, 9, 2,
      6, 11, 13, 8, 1, 4, 10, 7, 9, 5, 0, 15, 14, 2, 3, 12},
    '{13, 2, 8, 4, 6, 15, 11, 1, 10, 9, 3, 14, 5, 0, 12, 7,
      1, 15, 13, 8, 10, 3, 7, 4, 12, 5, 6, 11, 0, 14, 9, 2,
      7, 11, 4, 1, 9, 12, 14, 2, 0, 6, 10, 13, 15, 3, 5, 8,
      2, 1, 14, 7, 4, 10, 8, 13, 15, 12, 9, 0, 3, 5, 6, 11}};

  function automatic logic [63:0] perm_ip(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64-int'(TabIp[i])];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64-int'(TabFp[i])];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] x);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = x[64-int'(TabPc1[i])];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] x);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = x[56-int'(TabPc2[i])];
    return r;
  endfunction

  function automatic logic [27:0] rotl28(input logic [27:0] c, input logic [1:0] s);
    logic [27:0] r;
    r = c;
    if (s == 2'd1) r = {c[26:0], c[27]};
    else if (s == 2'd2) r = {c[25:0], c[27:26]};
    return r;
  endfunction

  // Inverse rotation, used to walk the key schedule backward.
  function automatic logic [27:0] rotr28(input logic [27:0] c, input logic [1:0] s);
    logic [27:0] r;
    r = c;
    if (s == 2'd1) r = {c[0], c[27:1]};
    else if (s == 2'd2) r = {c[1:0], c[27:2]};
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] half, input logic [47:0] rk);
    logic [47:0] e;
    logic [5:0] six;
    logic [31:0] s;
    logic [31:0] p;
    for (int i = 0; i < 48; i++) e[47-i] = half[32-int'(TabE[i])];
    e = e ^ rk;
    for (int b = 0; b < 8; b++) begin
      six = e[47-6*b -: 6];
      s[31-4*b -: 4] = TabSbox[b][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(TabP[i])];
    return p;
  endfunction

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
    logic [27:0] c;
    logic [27:0] d;
    logic        decrypt;
  } des_lane_t;

endpackage

FILE: design/des_block_cipher.sv
// ---------------------------------------------------------------------------
// DES block cipher
// ECB DES with sixteen round cells in a row and a registered output stage.
// ---------------------------------------------------------------------------
// Channel   Direction  Beat contents
// s_axis    in         tdata[63:0] = data_block
// m_axis    out        tdata[63:0] = result_block
// cfg       in         index 0 = cipher_key, 1 = decrypt_mode
//
// A block's output beat passes through one input register, sixteen round cells
// and one output register, the first loaded at the accepting edge. One block
// enters every cycle while the output is not stalled.
// Reset clears all valid flags, the key to zero and the mode to encrypt.
// An output stall freezes the whole row; bubbles in flight are kept as they are.
// ---------------------------------------------------------------------------
module des_block_cipher
  import des_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,   // [63:0] data_block
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [63:0]         m_axis_tdata,   // [63:0] result_block
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [63:0]         cfg_data
);

  logic [63:0] cipher_key;
  logic        decrypt_mode;
  logic        en;
  logic        valid [Rounds+1];
  des_lane_t   lane  [Rounds+1];
  logic [63:0] ip_out;
  logic [55:0] cd_init;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key   <= '0;
      decrypt_mode <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegKey:  cipher_key   <= cfg_data;
        RegMode: decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The row advances unless the output register is full and stalled.
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign ip_out  = perm_ip(s_axis_tdata);
  assign cd_init = perm_pc1(cipher_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane[0] <= '{left: ip_out[63:32], right: ip_out[31:0],
                   c: cd_init[55:28], d: cd_init[27:0], decrypt: decrypt_mode};
    end
  end

  for (genvar r = 0; r < Rounds; r++) begin : g_round
    des_round_cell #(.Round(r)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (valid[r]),
      .in_lane  (lane[r]),
      .out_valid(valid[r+1]),
      .out_lane (lane[r+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= valid[Rounds];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= perm_fp({lane[Rounds].right, lane[Rounds].left});
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready mismatched with output stage");
  a_last_cell_feeds: assert property (@(posedge clk) disable iff (rst)
    en && valid[Rounds] |=> m_axis_tvalid)
    else $error("finished block lost");

endmodule

FILE: design/des_round_cell.sv
// ---------------------------------------------------------------------------
// DES round cell
// One Feistel round plus its step of the key schedule, registered.
// ---------------------------------------------------------------------------
module des_round_cell
  import des_pkg::*;
#(
  parameter int Round = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  des_lane_t in_lane,
  output logic      out_valid,
  output des_lane_t out_lane
);

  localparam logic [1:0] RotFwd = TabRot[Round];
  localparam logic [1:0] RotBack = TabRot[Rounds - 1 - Round];

  logic [27:0] c_next;
  logic [27:0] d_next;
  logic [27:0] c_key;
  logic [27:0] d_key;
  logic [47:0] round_key;
  des_lane_t   lane_next;

  // Decryption starts from the round-16 halves, which equal the PC-1 halves,
  // and rotates right after each round.
  always_comb begin
    if (in_lane.decrypt) begin
      c_key  = in_lane.c;
      d_key  = in_lane.d;
      c_next = rotr28(in_lane.c, RotBack);
      d_next = rotr28(in_lane.d, RotBack);
    end else begin
      c_key  = rotl28(in_lane.c, RotFwd);
      d_key  = rotl28(in_lane.d, RotFwd);
      c_next = c_key;
      d_next = d_key;
    end
    round_key = perm_pc2({c_key, d_key});
    lane_next.left    = in_lane.right;
    lane_next.right   = in_lane.left ^ feistel(in_lane.right, round_key);
    lane_next.c       = c_next;
    lane_next.d       = d_next;
    lane_next.decrypt = in_lane.decrypt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lane <= lane_next;
    end
  end

endmodule
